/* hdl/gsp_pkg.sv */
// gsp_pkg: shared types and constants of the separable gaussian pass
// no dependencies; imported by every module of the block but gsp_ram

package gsp_pkg;

    localparam int SAMPLE_W   = 16;   // q12.4 sample
    localparam int COEFF_W    = 16;   // q0.16 coefficient
    localparam int PROD_W     = SAMPLE_W + COEFF_W + 1;
    localparam int ACC_W      = PROD_W + 4;   // room for up to sixteen products
    localparam int CFG_W      = 64;
    localparam int CFG_IDX_W  = 3;
    localparam int FIFO_DEPTH = 16;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_DIRECTION,
        CFG_EXTENT,
        CFG_ROW_LENGTH,
        CFG_COEFF_NEAR,
        CFG_COEFF_FAR
    } gsp_cfg_idx_t;

    // control that follows a window into the multiply-accumulate
    typedef struct packed {
        logic       valid;
        logic       last;
        logic [2:0] extent;
    } gsp_tag_t;

    // one finished result word
    typedef struct packed {
        logic                       valid;
        logic                       last;
        logic signed [SAMPLE_W-1:0] filtered;
    } gsp_result_t;

endpackage

/* hdl/gsp_ram.sv */
// gsp_ram: generic single-clock ram, one write port, one registered read port
// read-first on a same-address access; no dependencies

module gsp_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

/* hdl/gsp_mac.sv */
// gsp_mac: coefficient select, products, adder tree, rounding and saturation
// depends on gsp_pkg

module gsp_mac #(
    parameter int MAX_EXTENT = 6
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic [gsp_pkg::SAMPLE_W-1:0]  win_i [2*MAX_EXTENT+1],
    input  gsp_pkg::gsp_tag_t             tag_i,
    input  logic [gsp_pkg::CFG_W-1:0]     coeff_near_i,
    input  logic [gsp_pkg::CFG_W-1:0]     coeff_far_i,
    output gsp_pkg::gsp_result_t          res_o
);
    import gsp_pkg::*;

    localparam int WIN = 2 * MAX_EXTENT + 1;
    localparam int NG  = (WIN + 3) / 4;
    localparam int QW  = ACC_W - 16;

    logic [COEFF_W-1:0]       coeff_sel [WIN];
    logic [2*CFG_W-1:0]       coeff_all;
    logic signed [PROD_W-1:0] prod_reg  [WIN];
    logic signed [ACC_W-1:0]  part_reg  [NG];
    logic signed [ACC_W-1:0]  part_next [NG];
    logic signed [ACC_W-1:0]  sum_reg;
    logic signed [ACC_W-1:0]  sum_next;
    logic signed [ACC_W-1:0]  biased;
    logic signed [QW-1:0]     quot;
    logic signed [SAMPLE_W-1:0] sat_next;
    gsp_tag_t                 tag_p_reg, tag_a_reg, tag_s_reg;
    gsp_result_t              res_reg;

    assign coeff_all = {coeff_far_i, coeff_near_i};

    // offset |k - extent| picks the coefficient, taps past the kernel get zero
    always_comb begin
        int e;
        int ofs;
        e = int'(tag_i.extent);
        for (int k = 0; k < WIN; k++) begin
            ofs = (k >= e) ? (k - e) : (e - k);
            if (k <= 2 * e) begin
                coeff_sel[k] = coeff_all[16*ofs +: 16];
            end else begin
                coeff_sel[k] = '0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        for (int k = 0; k < WIN; k++) begin
            prod_reg[k] <= $signed(win_i[k]) * $signed({1'b0, coeff_sel[k]});
        end
    end

    // first level of the tree: groups of four products
    always_comb begin
        for (int g = 0; g < NG; g++) begin
            part_next[g] = '0;
            for (int j = 0; j < 4; j++) begin
                if (4 * g + j < WIN) begin
                    part_next[g] = part_next[g] + ACC_W'(prod_reg[4*g+j]);
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        part_reg <= part_next;
    end

    always_comb begin
        sum_next = '0;
        for (int g = 0; g < NG; g++) begin
            sum_next = sum_next + part_reg[g];
        end
    end

    always_ff @(posedge aclk) begin
        sum_reg <= sum_next;
    end

    // round half up, floor shift, clamp to q12.4
    always_comb begin
        biased = sum_reg + ACC_W'(32768);
        quot   = QW'(biased >>> 16);
        if (quot > QW'(32767)) begin
            sat_next = 16'sh7FFF;
        end else if (quot < -QW'(32768)) begin
            sat_next = 16'sh8000;
        end else begin
            sat_next = SAMPLE_W'(quot);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tag_p_reg     <= '0;
            tag_a_reg     <= '0;
            tag_s_reg     <= '0;
            res_reg.valid <= 1'b0;
        end else begin
            tag_p_reg     <= tag_i;
            tag_a_reg     <= tag_p_reg;
            tag_s_reg     <= tag_a_reg;
            res_reg.valid <= tag_s_reg.valid;
        end
        res_reg.last     <= tag_s_reg.last;
        res_reg.filtered <= sat_next;
    end

    assign res_o = res_reg;

endmodule

/* hdl/gsp_out_fifo.sv */
// gsp_out_fifo: small result queue in front of the master stream port
// depends on gsp_pkg

module gsp_out_fifo (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  gsp_pkg::gsp_result_t res_i,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [15:0]          m_tdata,   // [15:0] filtered
    output logic                 m_tlast    // row_end
);
    import gsp_pkg::*;

    localparam int PW = $clog2(FIFO_DEPTH);
    localparam int CW = $clog2(FIFO_DEPTH + 1);

    gsp_result_t    mem_reg [FIFO_DEPTH];
    logic [PW-1:0]  wr_ptr_reg, rd_ptr_reg;
    logic [CW-1:0]  count_reg, count_next;
    logic           push, pop;

    assign push = res_i.valid;
    assign pop  = m_tvalid && m_tready;

    always_comb begin
        count_next = count_reg;
        if (push && !pop) begin
            count_next = count_reg + CW'(1);
        end else if (pop && !push) begin
            count_next = count_reg - CW'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + PW'(1);
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + PW'(1);
            end
            count_reg <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= res_i;
        end
    end

    assign m_tvalid = (count_reg != '0);
    assign m_tdata  = mem_reg[rd_ptr_reg].filtered;
    assign m_tlast  = mem_reg[rd_ptr_reg].last;

endmodule

/* hdl/separable_gaussian_pass_top.sv */
// separable_gaussian_pass_top: one vertical or horizontal gaussian fir pass
// depends on gsp_pkg, gsp_ram, gsp_mac, gsp_out_fifo

// One pass of a symmetric gaussian fir over a border-padded image, taken in
// raster order at one word per clock while s_tready is high. Direction 0
// filters down columns using 2*MAX_EXTENT line-store banks (one gsp_ram of
// MAX_ROW words per line, all read at the current column while the current
// line's bank is written); direction 1 filters along rows in a shifting tap
// window. A filtered word leaves once 2*extent+1 samples are present, with
// m_tlast on the last word of an output row. From an accepted word to its
// result the path runs through the line-store read, the window update, the
// product stage, two adder-tree stages, rounding and the queue write. Results
// collect in a 16-word queue; s_tready drops only when the queue plus the
// words in flight that will produce a result would fill it, so the block keeps
// taking one word per clock while the master side stalls briefly. Line-store
// words must only be read after being written; the block itself does not
// enforce this, and there is no clearing pass after reset. Configuration
// writes are always accepted and should be made while no words are in flight.

module separable_gaussian_pass_top #(
    parameter int MAX_EXTENT = 6,
    parameter int MAX_ROW    = 1024
) (
    input  logic        aclk,
    input  logic        aresetn,
    // slave stream: input pixels
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,    // [15:0] sample
    input  logic        s_tuser,    // [0] frame_start
    // master stream: filtered pixels
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,    // [15:0] filtered
    output logic        m_tlast,    // row_end
    // configuration writes
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_addr,
    input  logic [63:0] cfg_data
);
    import gsp_pkg::*;

    localparam int RING = 2 * MAX_EXTENT;       // lines held for the column window
    localparam int WIN  = RING + 1;             // taps in the window
    localparam int CW   = $clog2(MAX_ROW);      // column index
    localparam int SW   = $clog2(RING);         // ring slot
    localparam int RCW  = $clog2(RING + 1);     // completed-row count
    localparam int KW   = $clog2(FIFO_DEPTH + 1);

    // configuration registers
    logic               direction_reg;
    logic [2:0]         extent_reg;
    logic [10:0]        row_length_reg;
    logic [CFG_W-1:0]   coeff_near_reg;
    logic [CFG_W-1:0]   coeff_far_reg;

    // position state
    logic [CW-1:0]      column_count_reg;
    logic [RCW-1:0]     row_count_reg;
    logic [SW-1:0]      line_slot_reg;

    // accept-stage logic
    logic               accept;
    logic [2:0]         ext_eff;
    logic [CW-1:0]      w_m1;
    logic [CW-1:0]      col_base, col;
    logic [RCW-1:0]     rows_base;
    logic               last, emit;

    // line-store read data, one word per bank
    logic [SAMPLE_W-1:0] bank_rd [RING];

    // stage after the memory read
    logic               p1_valid_reg;
    logic [SAMPLE_W-1:0] p1_sample_reg;
    logic               p1_dir_reg;
    logic [SW-1:0]      p1_slot_reg;
    logic               p1_emit_reg;
    logic               p1_last_reg;
    logic [2:0]         p1_extent_reg;
    logic [SW-1:0]      tap_bank [RING];

    // tap window
    logic [SAMPLE_W-1:0] window_reg  [WIN];
    logic [SAMPLE_W-1:0] window_next [WIN];
    gsp_tag_t           p2_tag_reg;

    gsp_result_t        mac_res;
    logic [KW-1:0]      credit_reg, credit_next;

    // ---------------------------------------------------------------
    // configuration port
    // ---------------------------------------------------------------
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            direction_reg  <= 1'b0;
            extent_reg     <= 3'd3;
            row_length_reg <= 11'd1024;
            coeff_near_reg <= '0;
            coeff_far_reg  <= '0;
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_addr)
                CFG_DIRECTION:  direction_reg  <= cfg_data[0];
                CFG_EXTENT:     extent_reg     <= cfg_data[2:0];
                CFG_ROW_LENGTH: row_length_reg <= cfg_data[10:0];
                CFG_COEFF_NEAR: coeff_near_reg <= cfg_data;
                CFG_COEFF_FAR:  coeff_far_reg  <= cfg_data;
                default: ;  // unmapped index, write dropped
            endcase
        end
    end

    // ---------------------------------------------------------------
    // accept stage: position, emit decision, line-store access
    // ---------------------------------------------------------------
    assign accept = s_tvalid && s_tready;

    // extent clamps to the widest kernel the window holds
    assign ext_eff = (int'(extent_reg) > MAX_EXTENT) ? 3'(MAX_EXTENT) : extent_reg;

    // last column index of the effective line width
    always_comb begin
        if (row_length_reg == '0) begin
            w_m1 = '0;
        end else if (int'(row_length_reg) > MAX_ROW) begin
            w_m1 = CW'(MAX_ROW - 1);
        end else begin
            w_m1 = CW'(row_length_reg - 11'd1);
        end
    end

    always_comb begin
        // a frame start clears the counters before this word is placed
        col_base  = s_tuser ? '0 : column_count_reg;
        rows_base = s_tuser ? '0 : row_count_reg;
        // a line that shrank under the current column ends here
        col  = (col_base > w_m1) ? w_m1 : col_base;
        last = (col == w_m1);
        if (direction_reg) begin
            emit = (int'(col) >= 2 * int'(ext_eff));
        end else begin
            emit = (int'(rows_base) >= 2 * int'(ext_eff));
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            column_count_reg <= '0;
            row_count_reg    <= '0;
            line_slot_reg    <= '0;
        end else if (accept) begin
            if (last) begin
                column_count_reg <= '0;
                row_count_reg    <= (int'(rows_base) < RING) ? rows_base + RCW'(1)
                                                             : rows_base;
                line_slot_reg    <= (int'(line_slot_reg) == RING - 1) ? '0
                                                         : line_slot_reg + SW'(1);
            end else begin
                column_count_reg <= col + CW'(1);
                row_count_reg    <= rows_base;
            end
        end
    end

    // one bank per buffered line; every bank is read at the current column,
    // the current line's bank returns its old word and takes the new one
    for (genvar b = 0; b < RING; b++) begin : g_bank
        gsp_ram #(
            .WIDTH (SAMPLE_W),
            .DEPTH (MAX_ROW)
        ) u_bank (
            .aclk  (aclk),
            .we    (accept && (line_slot_reg == SW'(b))),
            .waddr (col),
            .wdata (s_tdata),
            .raddr (col),
            .rdata (bank_rd[b])
        );
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p1_valid_reg <= 1'b0;
        end else begin
            p1_valid_reg <= accept;
        end
        p1_sample_reg <= s_tdata;
        p1_dir_reg    <= direction_reg;
        p1_slot_reg   <= line_slot_reg;
        p1_emit_reg   <= emit;
        p1_last_reg   <= last;
        p1_extent_reg <= ext_eff;
    end

    // ---------------------------------------------------------------
    // window stage: tap k of the column window is the line k back
    // ---------------------------------------------------------------
    always_comb begin
        int idx;
        for (int k = 1; k <= RING; k++) begin
            idx = int'(p1_slot_reg) + RING - k;
            if (idx >= RING) begin
                idx = idx - RING;
            end
            tap_bank[k-1] = SW'(idx);
        end
    end

    always_comb begin
        window_next = window_reg;
        if (p1_valid_reg) begin
            window_next[0] = p1_sample_reg;
            for (int k = 1; k < WIN; k++) begin
                if (p1_dir_reg) begin
                    window_next[k] = window_reg[k-1];
                end else begin
                    window_next[k] = bank_rd[tap_bank[k-1]];
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int k = 0; k < WIN; k++) begin
                window_reg[k] <= '0;
            end
            p2_tag_reg <= '0;
        end else begin
            window_reg       <= window_next;
            p2_tag_reg.valid <= p1_valid_reg && p1_emit_reg;
            p2_tag_reg.last  <= p1_last_reg;
            p2_tag_reg.extent <= p1_extent_reg;
        end
    end

    // ---------------------------------------------------------------
    // multiply-accumulate and result queue
    // ---------------------------------------------------------------
    gsp_mac #(
        .MAX_EXTENT (MAX_EXTENT)
    ) u_mac (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .win_i        (window_reg),
        .tag_i        (p2_tag_reg),
        .coeff_near_i (coeff_near_reg),
        .coeff_far_i  (coeff_far_reg),
        .res_o        (mac_res)
    );

    gsp_out_fifo u_out_fifo (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .res_i    (mac_res),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    // results owed: in flight toward the queue or waiting in it
    always_comb begin
        credit_next = credit_reg;
        if ((accept && emit) && !(m_tvalid && m_tready)) begin
            credit_next = credit_reg + KW'(1);
        end else if (!(accept && emit) && (m_tvalid && m_tready)) begin
            credit_next = credit_reg - KW'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            credit_reg <= '0;
        end else begin
            credit_reg <= credit_next;
        end
    end

    assign s_tready = (int'(credit_reg) < FIFO_DEPTH);

endmodule

/* tb/testbench.sv */
// testbench: self-checking bench for the separable gaussian pass
// depends on gsp_pkg and separable_gaussian_pass_top and, through it, the other design files

`timescale 1ns / 100ps

module testbench;

    import gsp_pkg::*;

    localparam int MAX_EXTENT   = 6;
    localparam int MAX_ROW      = 1024;
    localparam int RING         = 2 * MAX_EXTENT;   // line-store ring depth
    localparam int TAPS         = 2 * MAX_EXTENT + 1;
    localparam int PRIME_W      = 32;      // columns known written in every ring line
    localparam int PIXEL_BUDGET = 1300;    // directed and random words sent before the random passes stop
    localparam int SETTLE       = 12;      // pipeline drain plus margin
    localparam int CYCLE_LIMIT  = 1000000;

    // one expected result word
    typedef struct packed {
        logic signed [SAMPLE_W-1:0] filtered;
        logic                       row_end;
    } blur_word_t;

    logic        aclk = 1'b0;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [15:0] s_tdata;     // [15:0] sample
    logic        s_tuser;     // [0] frame_start
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [15:0] m_tdata;     // [15:0] filtered
    logic        m_tlast;     // row_end
    logic        cfg_valid;
    logic        cfg_ready;
    logic [2:0]  cfg_addr;
    logic [63:0] cfg_data;

    separable_gaussian_pass_top #(
        .MAX_EXTENT(MAX_EXTENT),
        .MAX_ROW   (MAX_ROW)
    ) dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_addr (cfg_addr),
        .cfg_data (cfg_data)
    );

    always #5 aclk = ~aclk;

    // shadow registers, reset values
    logic        sh_direction = 1'b0;
    logic [2:0]  sh_extent    = 3'd3;
    logic [10:0] sh_row       = 11'd1024;
    logic [63:0] sh_near      = '0;
    logic [63:0] sh_far       = '0;

    // shadow of the block's pixel state
    logic [15:0]  line_mem [0:RING*MAX_ROW-1];
    logic [15:0]  window   [0:TAPS-1] = '{default: '0};
    int unsigned  col_count = 0;
    int unsigned  row_count = 0;
    int unsigned  line_slot = 0;

    blur_word_t   blur_expected[$];
    int unsigned  pixels_sent = 0;
    int unsigned  mismatches  = 0;
    int unsigned  cycle_count = 0;

    // sender pacing
    int unsigned  burst_left = 0;
    bit           tx_steady  = 1'b0;

    function automatic logic [15:0] coeff_of(input int unsigned off);
        return (off < 4) ? sh_near[16*(off%4) +: 16] : sh_far[16*(off%4) +: 16];
    endfunction

    // advance the shadow state by one pixel and queue the word it produces, if any
    task automatic predict_blur(input logic [15:0] pix, input logic fs);
        int unsigned e, w, col, k, slot, off;
        logic        last, emit;
        longint      acc, q;
        blur_word_t  r;
        e = (sh_extent > MAX_EXTENT) ? MAX_EXTENT : int'(sh_extent);
        w = (sh_row == 0) ? 1 : (sh_row > MAX_ROW) ? MAX_ROW : int'(sh_row);
        if (fs) begin
            col_count = 0;
            row_count = 0;
        end
        col  = (col_count >= w) ? w - 1 : col_count;   // shrunken row ends here
        last = (col == w - 1);
        if (!sh_direction) begin
            // column window: tap k is k lines back at the same column
            window[0] = pix;
            for (k = 1; k < TAPS; k++) begin
                slot = (line_slot + RING - k) % RING;
                window[k] = line_mem[slot*MAX_ROW + col];
            end
            emit = (row_count >= 2 * e);
        end else begin
            for (k = TAPS - 1; k > 0; k--)
                window[k] = window[k-1];
            window[0] = pix;
            emit = (col >= 2 * e);
        end
        line_mem[line_slot*MAX_ROW + col] = pix;
        if (emit) begin
            acc = 0;
            for (k = 0; k < 2 * e + 1; k++) begin
                off = (k >= e) ? k - e : e - k;
                acc += longint'($signed(window[k])) * longint'(coeff_of(off));
            end
            // round half up then clamp to q12.4
            q = (acc + 32768) >>> 16;
            if (q > 32767)
                q = 32767;
            else if (q < -32768)
                q = -32768;
            r.filtered = q[15:0];
            r.row_end  = last;
            blur_expected.push_back(r);
        end
        if (last) begin
            col_count = 0;
            if (row_count < RING)
                row_count++;
            line_slot = (line_slot + 1) % RING;
        end else begin
            col_count = col + 1;
        end
    endtask

    // one register write; cfg_valid stays up for a following write
    task automatic reg_write(input gsp_cfg_idx_t idx, input logic [63:0] value);
        cfg_valid <= 1'b1;
        cfg_addr  <= idx;
        cfg_data  <= value;
        @(posedge aclk);
        while (!cfg_ready)
            @(posedge aclk);
        case (idx)
            CFG_DIRECTION:  sh_direction = value[0];
            CFG_EXTENT:     sh_extent    = value[2:0];
            CFG_ROW_LENGTH: sh_row       = value[10:0];
            CFG_COEFF_NEAR: sh_near      = value;
            CFG_COEFF_FAR:  sh_far       = value;
            default: ;
        endcase
    endtask

    task automatic set_all(input logic dir, input logic [2:0] ext, input logic [10:0] row,
                           input logic [63:0] near, input logic [63:0] far);
        reg_write(CFG_DIRECTION, 64'(dir));
        reg_write(CFG_EXTENT, 64'(ext));
        reg_write(CFG_ROW_LENGTH, 64'(row));
        reg_write(CFG_COEFF_NEAR, near);
        reg_write(CFG_COEFF_FAR, far);
        cfg_valid <= 1'b0;
    endtask

    // send one pixel word, predict on acceptance, then maybe take a gap
    task automatic send_pixel(input logic [15:0] pix, input logic fs);
        s_tvalid <= 1'b1;
        s_tdata  <= pix;
        s_tuser  <= fs;
        @(posedge aclk);
        while (!s_tready)
            @(posedge aclk);
        predict_blur(pix, fs);
        pixels_sent++;
        if (!tx_steady) begin
            if (burst_left > 0) begin
                burst_left--;
            end else begin
                burst_left = $urandom_range(0, 15);
                s_tvalid <= 1'b0;
                repeat ($urandom_range(1, 6)) @(posedge aclk);
            end
        end
    endtask

    // hold the sender until every expected word is back and the pipe is empty
    task automatic wait_idle();
        s_tvalid <= 1'b0;
        while (blur_expected.size() != 0)
            @(posedge aclk);
        repeat (SETTLE) @(posedge aclk);
    endtask

    function automatic logic [15:0] pick_pixel();
        logic [15:0] p;
        case ($urandom_range(0, 9))
            0:       p = 16'h8000;
            1:       p = 16'h7FFF;
            2:       p = 16'hFFFF;
            3, 4, 5: p = 16'($urandom_range(0, 511) - 256);
            default: p = 16'($urandom);
        endcase
        return p;
    endfunction

    function automatic logic [63:0] pick_coeffs();
        logic [63:0] c;
        int          i;
        for (i = 0; i < 4; i++) begin
            case ($urandom_range(0, 5))
                0:       c[16*i +: 16] = 16'h0000;
                1:       c[16*i +: 16] = 16'hFFFF;
                2, 3:    c[16*i +: 16] = 16'($urandom_range(0, 16'h3FFF));
                default: c[16*i +: 16] = 16'($urandom);
            endcase
        end
        return c;
    endfunction

    // registers at reset: only the direction is changed, zero coefficients give zeros
    task automatic test_reset_defaults();
        int i;
        reg_write(CFG_DIRECTION, 64'd1);
        cfg_valid <= 1'b0;
        for (i = 0; i < 8; i++)
            send_pixel((i % 2) ? 16'h8000 : 16'h7FFF, i == 0);
        wait_idle();
    endtask

    // single tap, row length zero taken as one: every word ends its row
    task automatic test_single_tap();
        set_all(1'b1, 3'd0, 11'd0, 64'h0000_0000_0000_FFFF, 64'd0);
        send_pixel(16'h7FFF, 1'b1);
        send_pixel(16'h8000, 1'b0);
        send_pixel(16'h0000, 1'b0);
        send_pixel(16'hFFFF, 1'b0);
        wait_idle();
    endtask

    // extent above the maximum, row shorter than the window, oversize row length
    task automatic test_window_clamps();
        int i;
        set_all(1'b1, 3'd7, 11'd3, 64'h2EE0_1F40_0FA0_07D0, 64'h03E8_0258_012C_0064);
        for (i = 0; i < 3; i++)
            send_pixel(pick_pixel(), i == 0);
        wait_idle();
        reg_write(CFG_ROW_LENGTH, 64'd2047);
        cfg_valid <= 1'b0;
        for (i = 0; i < 13; i++)
            send_pixel(pick_pixel(), i == 0);
        wait_idle();
    endtask

    // all-ones coefficients drive the sum past both rails
    task automatic test_saturation();
        int i;
        set_all(1'b1, 3'd1, 11'd3, '1, '1);
        for (i = 0; i < 3; i++)
            send_pixel(16'h7FFF, i == 0);
        for (i = 0; i < 3; i++)
            send_pixel(16'h8000, 1'b0);
        wait_idle();
    endtask

    // twelve horizontal rows fill every ring line before any column pass reads it
    task automatic test_line_prime();
        int i;
        set_all(1'b1, 3'($urandom_range(0, 7)), 11'(PRIME_W), pick_coeffs(), pick_coeffs());
        for (i = 0; i < RING * PRIME_W; i++)
            send_pixel(pick_pixel(), i == 0);
        wait_idle();
    endtask

    // full-size row, then shrink the row under the current column
    task automatic test_long_row_shrink();
        int i;
        set_all(1'b1, 3'd2, 11'd1024, pick_coeffs(), pick_coeffs());
        for (i = 0; i < 40; i++)
            send_pixel(pick_pixel(), i == 0);
        wait_idle();
        reg_write(CFG_ROW_LENGTH, 64'd10);
        cfg_valid <= 1'b0;
        for (i = 0; i < 12; i++)
            send_pixel(pick_pixel(), 1'b0);
        wait_idle();
    endtask

    // one random setting and a frame under it, sometimes reconfigured part way
    task automatic run_random_phase();
        logic        dir, fs;
        logic [10:0] row;
        int unsigned w, e, rows, n, split, i;
        dir = ($urandom_range(0, 9) < 6) ? 1'b0 : 1'b1;
        if (!dir) begin
            // column passes stay inside the primed columns
            if ($urandom_range(0, 9) == 0)
                row = '0;
            else if ($urandom_range(0, 3) == 0)
                row = 11'($urandom_range(11, PRIME_W));
            else
                row = 11'($urandom_range(1, 10));
        end else begin
            case ($urandom_range(0, 9))
                0:       row = '0;
                1:       row = 11'($urandom_range(1025, 2047));
                2:       row = 11'($urandom_range(100, 1024));
                default: row = 11'($urandom_range(1, 24));
            endcase
        end
        tx_steady = ($urandom_range(0, 3) == 0);
        wait_idle();
        reg_write(CFG_DIRECTION, 64'(dir));
        if ($urandom_range(0, 3) != 0)
            reg_write(CFG_EXTENT, 64'($urandom_range(0, 7)));
        if (!dir || $urandom_range(0, 4) != 0)
            reg_write(CFG_ROW_LENGTH, 64'(row));
        if ($urandom_range(0, 2) != 0)
            reg_write(CFG_COEFF_NEAR, pick_coeffs());
        if ($urandom_range(0, 2) != 0)
            reg_write(CFG_COEFF_FAR, pick_coeffs());
        cfg_valid <= 1'b0;

        e = (sh_extent > MAX_EXTENT) ? MAX_EXTENT : int'(sh_extent);
        w = (sh_row == 0) ? 1 : (sh_row > MAX_ROW) ? MAX_ROW : int'(sh_row);
        if (w > 64) begin
            n = $urandom_range(16, 80);
        end else begin
            rows = dir ? $urandom_range(1, 3) : 2 * e + $urandom_range(1, 3);
            n = w * rows;
        end
        split = ($urandom_range(0, 2) == 0) ? $urandom_range(1, n) : n;
        for (i = 0; i < n; i++) begin
            if (i == split) begin
                // mid-frame change: the window mixes old and new settings
                wait_idle();
                if ($urandom_range(0, 1))
                    reg_write(CFG_ROW_LENGTH, 64'($urandom_range(0, w)));
                if ($urandom_range(0, 2) == 0)
                    reg_write(CFG_EXTENT, 64'($urandom_range(0, 7)));
                cfg_valid <= 1'b0;
            end
            // mostly clean frames, with a rare stray frame start as noise
            fs = (i == 0) ? ($urandom_range(0, 9) != 0) : ($urandom_range(0, 199) == 0);
            send_pixel(pick_pixel(), fs);
        end
    endtask

    task automatic test_random_passes();
        while (pixels_sent < PIXEL_BUDGET)
            run_random_phase();
        tx_steady = 1'b0;
    endtask

    // receiver: segments of always ready, coin flips, light stalls and full stops
    always @(posedge aclk) begin : rx_pattern
        int unsigned rx_left;
        int unsigned rx_mode;
        if (rx_left == 0) begin
            rx_mode = $urandom_range(0, 4);
            rx_left = $urandom_range(4, 60);
        end else begin
            rx_left--;
        end
        case (rx_mode)
            0, 1:    m_tready <= 1'b1;
            2:       m_tready <= 1'($urandom_range(0, 1));
            3:       m_tready <= ($urandom_range(0, 3) != 0);
            default: m_tready <= 1'b0;
        endcase
    end

    // compare every accepted result word against the oldest prediction
    always @(posedge aclk) begin : check_words
        blur_word_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (blur_expected.size() == 0) begin
                $display("%0t: unexpected word: expected none, got filtered %0d row_end %0b",
                         $time, $signed(m_tdata), m_tlast);
                mismatches++;
            end else begin
                want = blur_expected.pop_front();
                if (m_tdata !== want.filtered) begin
                    $display("%0t: filtered: expected %0d, got %0d",
                             $time, want.filtered, $signed(m_tdata));
                    mismatches++;
                end
                if (m_tlast !== want.row_end) begin
                    $display("%0t: row_end: expected %0b, got %0b",
                             $time, want.row_end, m_tlast);
                    mismatches++;
                end
            end
        end
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    initial begin
        aresetn   <= 1'b0;
        s_tvalid  <= 1'b0;
        s_tdata   <= '0;
        s_tuser   <= 1'b0;
        cfg_valid <= 1'b0;
        cfg_addr  <= CFG_DIRECTION;
        cfg_data  <= '0;
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_reset_defaults();
        test_single_tap();
        test_window_clamps();
        test_saturation();
        test_line_prime();
        test_long_row_shrink();
        test_random_passes();

        wait_idle();
        if (mismatches == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
